// ===== rtl/core/hsj_pkg.sv =====
// shared constants, codes and control structs for the halton jitter block
`default_nettype none
package hsj_pkg;

   localparam int CFG_W       = 14;
   localparam int FRAC_W      = 16;
   localparam int JIT_W       = 16;
   localparam int DATA_W      = 32;
   localparam int FRAME_W     = 32;
   localparam int PHASE_OUT_W = 4;
   localparam int SEQ_LEN_DEF = 16;

   // base-3 digit path: index, numerator and denominator (3^7 = 2187 fits)
   localparam int RAD_W     = 12;
   // floor(i/3) = (i * 2731) >> 13, exact for i < 4096
   localparam int RECIP3    = 2731;
   localparam int RECIP3_SH = 13;

   // shared restoring divider
   localparam int DVD_W       = 17;
   localparam int REM_W       = 14;
   localparam int QUO_W       = 17;
   localparam int CNT_W       = 5;
   localparam int RAD_STEPS   = 16;
   localparam int SCALE_STEPS = 17;

   localparam logic [CFG_W-1:0] WIDTH_RST  = 14'd1920;
   localparam logic [CFG_W-1:0] HEIGHT_RST = 14'd1080;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [REM_W-1:0]  rem_init;
      logic [CFG_W-1:0]  divisor;
      logic [CNT_W-1:0]  steps;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [QUO_W-1:0]  quotient;
   } div_rsp_type;

   typedef struct packed {
      logic              done;
      logic [RAD_W-1:0]  num;
      logic [RAD_W-1:0]  den;
   } dig_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/hsj_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module hsj_div
   import hsj_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_cmd_type cmd,
   output div_rsp_type      rsp
);

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CFG_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [REM_W:0]   trial;
   logic [REM_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = cmd.rem_init;
         dvd_in  = cmd.dividend;
         quo_in  = '0;
         div_in  = cmd.divisor;
         cnt_in  = cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/core/hsj_rad3.sv =====
// base-3 digit extractor: builds numerator and denominator of the radical inverse
`default_nettype none
module hsj_rad3
   import hsj_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [RAD_W-1:0] idx,
   output dig_rsp_type           rsp
);

   logic [RAD_W-1:0]   i_ff, i_in;
   logic [RAD_W-1:0]   num_ff, num_in;
   logic [RAD_W-1:0]   den_ff, den_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [2*RAD_W-1:0] prod;
   logic [RAD_W-1:0]   quo;
   logic [RAD_W-1:0]   three_q;
   logic [1:0]         digit;

   // divide by three through the reciprocal
   assign prod    = i_ff * RAD_W'(RECIP3);
   assign quo     = RAD_W'(prod >> RECIP3_SH);
   assign three_q = quo + {quo[RAD_W-2:0], 1'b0};
   assign digit   = 2'(i_ff - three_q);

   always_comb begin
      i_in    = i_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         i_in    = idx;
         num_in  = '0;
         den_in  = RAD_W'(1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff + {num_ff[RAD_W-2:0], 1'b0} + RAD_W'(digit);
         den_in = den_ff + {den_ff[RAD_W-2:0], 1'b0};
         i_in   = quo;
         if (quo == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      i_ff   <= i_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.num  = num_ff;
   assign rsp.den  = den_ff;

endmodule
`default_nettype wire

// ===== rtl/core/halton_subpixel_jitter_top.sv =====
// halton sub-pixel jitter: sequencer, frame counters and output register
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | proj_x, proj_y, advance
//   rsp     | out       | rsp_valid/stall    | jitter_x/y, out_x/y, seq_phase, frame_count
//   csr     | in        | csr_wr_en          | csr_index, csr_wdata
//
// one item at a time; the result is offered once the item has passed the base-3 digit
// loop, whose length follows the number of base-3 digits of the index, and the divider:
// 16 bits for the base-3 fraction and 17 bits for each viewport scaling, one bit per
// cycle, with the state machine handing over between the steps.
// reset is synchronous and returns the frame and phase counters to zero.
// a stalled result holds in the output register while the next item already runs.
`default_nettype none
module halton_subpixel_jitter_top
   import hsj_pkg::*;
#(
   parameter int SEQ_LEN = SEQ_LEN_DEF
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [DATA_W-1:0] req_proj_x,
   input  wire logic signed [DATA_W-1:0] req_proj_y,
   input  wire logic                     req_advance,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [JIT_W-1:0]       rsp_jitter_x,
   output logic signed [JIT_W-1:0]       rsp_jitter_y,
   output logic signed [DATA_W-1:0]      rsp_out_x,
   output logic signed [DATA_W-1:0]      rsp_out_y,
   output logic [PHASE_OUT_W-1:0]        rsp_seq_phase,
   output logic [FRAME_W-1:0]            rsp_frame_count,
   input  wire logic                     csr_wr_en,
   input  wire csr_idx_type              csr_index,
   input  wire logic [CFG_W-1:0]         csr_wdata
);

   localparam int PH_W  = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
   localparam int IDX_W = $clog2(SEQ_LEN + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIGIT = 6'b000010,
      ST_DIV3  = 6'b000100,
      ST_DIVX  = 6'b001000,
      ST_DIVY  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   function automatic logic [JIT_W-1:0] mag_of(input logic [JIT_W-1:0] j);
      return j[JIT_W-1] ? (~j + JIT_W'(1)) : j;
   endfunction

   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] p,
                                                 input logic [JIT_W-1:0]  j,
                                                 input logic [QUO_W-1:0]  q);
      logic [QUO_W:0]    sq;
      logic [DATA_W+1:0] sum;
      logic [DATA_W-1:0] res;
      sq  = j[JIT_W-1] ? (~{1'b0, q} + (QUO_W+1)'(1)) : {1'b0, q};
      sum = {{2{p[DATA_W-1]}}, p} + {{(DATA_W+1-QUO_W){sq[QUO_W]}}, sq};
      if (sum[DATA_W+1:DATA_W-1] == 3'b000 || sum[DATA_W+1:DATA_W-1] == 3'b111) begin
         res = sum[DATA_W-1:0];
      end else if (sum[DATA_W+1]) begin
         res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return res;
   endfunction

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  width_ff, height_ff;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [PH_W-1:0]   phase_ff, phase_in;

   logic [DATA_W-1:0] px_ff, py_ff;
   logic [FRAME_W-1:0] frame_q_ff;
   logic [PH_W-1:0]   phase_q_ff;
   logic [JIT_W-1:0]  jx_ff, jx_in;
   logic [JIT_W-1:0]  jy_ff, jy_in;
   logic [QUO_W-1:0]  sx_ff, sx_in;
   logic [QUO_W-1:0]  sy_ff, sy_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [JIT_W-1:0]  rsp_jx_ff, rsp_jy_ff;
   logic [DATA_W-1:0] rsp_ox_ff, rsp_oy_ff;
   logic [PHASE_OUT_W-1:0] rsp_ph_ff;
   logic [FRAME_W-1:0] rsp_fc_ff;

   logic              accept;
   logic              load_out;
   logic [IDX_W-1:0]  idx;
   logic [FRAC_W-1:0] frac2;
   logic [FRAC_W-1:0] frac3;
   logic [CFG_W-1:0]  width_eff, height_eff;
   logic [PH_W+PHASE_OUT_W-1:0] phase_ext;

   div_cmd_type       div_cmd;
   div_rsp_type       div_rsp;
   dig_rsp_type       dig_rsp;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign load_out = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign idx        = IDX_W'(phase_ff) + IDX_W'(1);
   assign width_eff  = (width_ff == '0) ? CFG_W'(1) : width_ff;
   assign height_eff = (height_ff == '0) ? CFG_W'(1) : height_ff;
   assign frac3      = div_rsp.quotient[FRAC_W-1:0];
   assign phase_ext  = {{PHASE_OUT_W{1'b0}}, phase_q_ff};

   // base-2 radical inverse is the index bit-reversed behind the binary point
   always_comb begin
      frac2 = '0;
      for (int b = 0; b < IDX_W; b++) begin
         frac2[FRAC_W-1-b] = idx[b];
      end
   end

   hsj_rad3 u_rad3 (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .idx   (RAD_W'(idx)),
      .rsp   (dig_rsp)
   );

   hsj_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      jx_in    = jx_ff;
      jy_in    = jy_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      div_cmd  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               jx_in    = {~frac2[FRAC_W-1], frac2[FRAC_W-2:0]};
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (dig_rsp.done) begin
               div_cmd.start    = 1'b1;
               div_cmd.rem_init = REM_W'(dig_rsp.num);
               div_cmd.divisor  = CFG_W'(dig_rsp.den);
               div_cmd.steps    = CNT_W'(RAD_STEPS);
               state_in         = ST_DIV3;
            end
         end
         ST_DIV3: begin
            if (div_rsp.done) begin
               jy_in            = {~frac3[FRAC_W-1], frac3[FRAC_W-2:0]};
               div_cmd.start    = 1'b1;
               div_cmd.dividend = {mag_of(jx_ff), 1'b0};
               div_cmd.divisor  = width_eff;
               div_cmd.steps    = CNT_W'(SCALE_STEPS);
               state_in         = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (div_rsp.done) begin
               sx_in            = div_rsp.quotient;
               div_cmd.start    = 1'b1;
               div_cmd.dividend = {mag_of(jy_ff), 1'b0};
               div_cmd.divisor  = height_eff;
               div_cmd.steps    = CNT_W'(SCALE_STEPS);
               state_in         = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_rsp.done) begin
               sy_in    = div_rsp.quotient;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // counters step at a transfer in with advance set; the item keeps its own copy
   always_comb begin
      frame_in = frame_ff;
      phase_in = phase_ff;
      if (accept && req_advance) begin
         frame_in = frame_ff + FRAME_W'(1);
         if (frame_in == '0 || phase_ff == PH_W'(SEQ_LEN - 1)) begin
            phase_in = '0;
         end else begin
            phase_in = phase_ff + PH_W'(1);
         end
      end
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_RST;
         height_ff    <= HEIGHT_RST;
         frame_ff     <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_wdata;
               CSR_HEIGHT: height_ff <= csr_wdata;
               default:    ;
            endcase
         end
      end
      if (accept) begin
         px_ff      <= req_proj_x;
         py_ff      <= req_proj_y;
         frame_q_ff <= frame_ff;
         phase_q_ff <= phase_ff;
      end
      jx_ff <= jx_in;
      jy_ff <= jy_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      if (load_out) begin
         rsp_jx_ff <= jx_ff;
         rsp_jy_ff <= jy_ff;
         rsp_ox_ff <= sat_add(px_ff, jx_ff, sx_ff);
         rsp_oy_ff <= sat_add(py_ff, jy_ff, sy_ff);
         rsp_ph_ff <= phase_ext[PHASE_OUT_W-1:0];
         rsp_fc_ff <= frame_q_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_jitter_x    = rsp_jx_ff;
   assign rsp_jitter_y    = rsp_jy_ff;
   assign rsp_out_x       = rsp_ox_ff;
   assign rsp_out_y       = rsp_oy_ff;
   assign rsp_seq_phase   = rsp_ph_ff;
   assign rsp_frame_count = rsp_fc_ff;

endmodule
`default_nettype wire

// ===== rtl/core/hsj_chk.sv =====
// port-level checks for the halton jitter block and their binding
`default_nettype none
module hsj_chk
   import hsj_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [JIT_W-1:0] rsp_jitter_x
);

   // a held result stays offered until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // only one item in flight: the input closes right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // base-2 jitter of an index up to 1024 has its low five fraction bits clear
   a_jit_x_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_jitter_x[4:0] == 5'd0)
      else $error("x jitter off the base-2 grid");

   // no result right out of reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind halton_subpixel_jitter_top hsj_chk u_hsj_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_jitter_x (rsp_jitter_x)
);
`default_nettype wire
